@@ src/pixel_format_converter_core_assert.svh @@
// assertion helpers for the pixel format converter
`ifndef PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfc check failed");

// next-cycle implication, checked out of reset
`define PFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfc check failed");

`endif

@@ src/pfc_pkg.sv @@
`default_nettype none
package pfc_pkg;

    localparam int WORD_W   = 32;
    localparam int CHAN_W   = 8;
    localparam int SHIFT_W  = 5;
    localparam int DVD_W    = 41;
    localparam int NCELL    = DVD_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] CHAN_MAX = 32'd255;
    localparam logic [DVD_W-1:0]  RND_PACK = 41'd127;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 2'd3;

    // pixel formats
    localparam logic [1:0] FMT_RGBX = 2'd0;
    localparam logic [1:0] FMT_BGRX = 2'd1;
    localparam logic [1:0] FMT_MASK = 2'd2;
    localparam logic [1:0] FMT_BAD  = 2'd3;

    // one division cell's working set
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DVD_W-1:0]  dvd;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
    } t_div;

    // per-channel mask geometry
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [WORD_W-1:0]  maxv;
    } t_geo;

    // item data that bypasses the dividers
    typedef struct packed {
        logic              func;
        logic              use_div;
        logic [WORD_W-1:0] packed_word;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              bad;
    } t_side;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              bad;
    } t_res;

    // lowest run of ones: shift and all-ones value of its width
    function automatic t_geo f_geo(input logic [WORD_W-1:0] mask);
        t_geo              g;
        logic [WORD_W-1:0] low;
        logic [WORD_W:0]   sum;
        logic [WORD_W-1:0] run;
        g.shift = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (mask[i]) g.shift = SHIFT_W'(i);
        end
        low    = mask & (~mask + 1'b1);
        sum    = {1'b0, mask} + {1'b0, low};
        run    = mask & ~sum[WORD_W-1:0];
        g.maxv = run >> g.shift;
        return g;
    endfunction

    // dividend and divisor for one channel
    function automatic t_div f_head(input logic func, input logic [CHAN_W-1:0] v8,
                                    input logic [WORD_W-1:0] word,
                                    input logic [WORD_W-1:0] mask, input t_geo g);
        t_div                d;
        logic [WORD_W-1:0]   v32;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
        logic [2*WORD_W-1:0] prod;
        v32   = (word & mask) >> g.shift;
        a     = func ? v32 : {{(WORD_W-CHAN_W){1'b0}}, v8};
        b     = func ? CHAN_MAX : g.maxv;
        prod  = a * b;
        d.dvd = prod[DVD_W-1:0]
              + (func ? {{(DVD_W-WORD_W){1'b0}}, g.maxv >> 1} : RND_PACK);
        d.dvs = func ? g.maxv : CHAN_MAX;
        d.rem = '0;
        d.quo = '0;
        return d;
    endfunction

endpackage
`default_nettype wire

@@ src/pfc_ifs.sv @@
`default_nettype none
// pixel item channel into the block
interface pfc_pix_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [31:0] raw_word;
    modport source (output valid, func, in_red, in_green, in_blue, raw_word, input ready);
    modport sink (input valid, func, in_red, in_green, in_blue, raw_word, output ready);
endinterface

// result item channel out of the block
interface pfc_pix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        format_bad;
    modport source (output valid, packed_word, out_red, out_green, out_blue, format_bad,
                    input ready);
    modport sink (input valid, packed_word, out_red, out_green, out_blue, format_bad,
                  output ready);
endinterface

// register write channel
interface pfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/pfc_div_cell.sv @@
`default_nettype none
// one restoring division step: takes one dividend bit, yields one quotient bit
module pfc_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  pfc_pkg::t_div      i_d,
    output pfc_pkg::t_div      o_d
);
    logic [pfc_pkg::WORD_W:0] w_trial;
    logic                     w_ge;
    pfc_pkg::t_div            n_d;
    pfc_pkg::t_div            r_d;

    // shift in next dividend bit and try the subtract
    always_comb begin
        w_trial = {i_d.rem, i_d.dvd[pfc_pkg::DVD_W-1]};
        w_ge    = w_trial >= {1'b0, i_d.dvs};
        n_d.dvs = i_d.dvs;
        n_d.dvd = {i_d.dvd[pfc_pkg::DVD_W-2:0], 1'b0};
        n_d.quo = {i_d.quo[pfc_pkg::WORD_W-2:0], w_ge};
        n_d.rem = w_ge ? pfc_pkg::WORD_W'(w_trial - {1'b0, i_d.dvs})
                       : pfc_pkg::WORD_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

@@ src/pfc_div_chain.sv @@
`default_nettype none
// row of division cells for one channel, one dividend bit per cell
module pfc_div_chain (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  pfc_pkg::t_div i_head,
    output pfc_pkg::t_div o_tail
);
    pfc_pkg::t_div w_stg [pfc_pkg::NCELL+1];

    assign w_stg[0] = i_head;

    for (genvar k = 0; k < pfc_pkg::NCELL; k++) begin : g_cell
        pfc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_stg[k]),
            .o_d   (w_stg[k+1])
        );
    end

    assign o_tail = w_stg[pfc_pkg::NCELL];
endmodule
`default_nettype wire

@@ src/pixel_format_converter_core.sv @@
// Pixel format converter: packs 8-bit red, green and blue into a 32-bit
// framebuffer word, or unpacks a word back into channels, as each item's func
// asks, under the byte orders or channel masks held in the registers. One item
// is accepted per clock while the skid is empty; each result passes an entry
// register, 41 restoring division cells per channel and the output register.
// A held result stops intake only once a second one stacks behind it in the
// skid register. Registers must be written only while no item is in flight,
// which the block does not enforce; the mask geometry is derived on write.
`default_nettype none
`include "pixel_format_converter_core_assert.svh"
module pixel_format_converter_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pfc_pix_in_if.sink     i_pix,
    pfc_pix_out_if.source  o_pix,
    pfc_cfg_if.sink        i_cfg
);
    localparam int NC = pfc_pkg::NCELL;

    logic [1:0]                 r_fmt;
    logic [pfc_pkg::WORD_W-1:0] r_mask [3];
    pfc_pkg::t_geo              r_geo  [3];

    logic                       r_vld  [NC+1];
    pfc_pkg::t_side             r_side [NC+1];
    pfc_pkg::t_div              r_head [3];
    pfc_pkg::t_div              w_tail [3];
    pfc_pkg::t_side             n_side;
    pfc_pkg::t_res              w_res;
    pfc_pkg::t_res              r_out;
    pfc_pkg::t_res              r_skid;
    logic                       r_out_v;
    logic                       r_skid_v;
    logic                       w_adv;
    logic                       w_acc;
    logic [pfc_pkg::CHAN_W-1:0] w_v8 [3];

    assign w_adv       = ~r_skid_v;
    assign i_pix.ready = w_adv;
    assign w_acc       = i_pix.valid & w_adv;
    assign i_cfg.ready = 1'b1;

    // register writes, geometry computed from the written mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= pfc_pkg::FMT_RGBX;
            for (int c = 0; c < 3; c++) begin
                r_mask[c] <= '0;
                r_geo[c]  <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pfc_pkg::REG_FORMAT: r_fmt <= i_cfg.data[1:0];
                pfc_pkg::REG_RED: begin
                    r_mask[0] <= i_cfg.data;
                    r_geo[0]  <= pfc_pkg::f_geo(i_cfg.data);
                end
                pfc_pkg::REG_GREEN: begin
                    r_mask[1] <= i_cfg.data;
                    r_geo[1]  <= pfc_pkg::f_geo(i_cfg.data);
                end
                pfc_pkg::REG_BLUE: begin
                    r_mask[2] <= i_cfg.data;
                    r_geo[2]  <= pfc_pkg::f_geo(i_cfg.data);
                end
                default: ;
            endcase
        end
    end

    assign w_v8[0] = i_pix.in_red;
    assign w_v8[1] = i_pix.in_green;
    assign w_v8[2] = i_pix.in_blue;

    // byte-order formats and the invalid format resolve at entry
    always_comb begin
        n_side             = '0;
        n_side.func        = i_pix.func;
        n_side.use_div     = (r_fmt == pfc_pkg::FMT_MASK);
        n_side.bad         = (r_fmt == pfc_pkg::FMT_BAD);
        unique case (r_fmt)
            pfc_pkg::FMT_RGBX: begin
                if (i_pix.func) begin
                    n_side.red   = i_pix.raw_word[7:0];
                    n_side.green = i_pix.raw_word[15:8];
                    n_side.blue  = i_pix.raw_word[23:16];
                end else begin
                    n_side.packed_word = {8'd0, i_pix.in_blue, i_pix.in_green, i_pix.in_red};
                end
            end
            pfc_pkg::FMT_BGRX: begin
                if (i_pix.func) begin
                    n_side.blue  = i_pix.raw_word[7:0];
                    n_side.green = i_pix.raw_word[15:8];
                    n_side.red   = i_pix.raw_word[23:16];
                end else begin
                    n_side.packed_word = {8'd0, i_pix.in_red, i_pix.in_green, i_pix.in_blue};
                end
            end
            default: ;
        endcase
    end

    // entry register: scaled dividend per channel, side data travels alongside the cells
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side;
            for (int k = 0; k < NC; k++) r_side[k+1] <= r_side[k];
            for (int c = 0; c < 3; c++) begin
                r_head[c] <= pfc_pkg::f_head(i_pix.func, w_v8[c], i_pix.raw_word,
                                             r_mask[c], r_geo[c]);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        pfc_div_chain u_chain (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_head (r_head[c]),
            .o_tail (w_tail[c])
        );
    end

    // valid bits travel alongside the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NC; k++) r_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= w_acc;
            for (int k = 0; k < NC; k++) r_vld[k+1] <= r_vld[k];
        end
    end

    // final assembly from the quotients
    always_comb begin
        w_res.packed_word = r_side[NC].packed_word;
        w_res.red         = r_side[NC].red;
        w_res.green       = r_side[NC].green;
        w_res.blue        = r_side[NC].blue;
        w_res.bad         = r_side[NC].bad;
        if (r_side[NC].use_div) begin
            if (r_side[NC].func) begin
                w_res.red   = (r_geo[0].maxv != '0) ? w_tail[0].quo[7:0] : '0;
                w_res.green = (r_geo[1].maxv != '0) ? w_tail[1].quo[7:0] : '0;
                w_res.blue  = (r_geo[2].maxv != '0) ? w_tail[2].quo[7:0] : '0;
            end else begin
                w_res.packed_word = '0;
                for (int c = 0; c < 3; c++) begin
                    if (r_geo[c].maxv != '0)
                        w_res.packed_word = w_res.packed_word
                                          | (w_tail[c].quo << r_geo[c].shift);
                end
            end
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_pix.ready) r_skid_v <= 1'b0;
        end else if (!r_out_v || o_pix.ready) begin
            r_out_v <= r_vld[NC];
        end else if (r_vld[NC]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_pix.ready) r_out <= r_skid;
        end else if (!r_out_v || o_pix.ready) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_pix.valid       = r_out_v;
    assign o_pix.packed_word = r_out.packed_word;
    assign o_pix.out_red     = r_out.red;
    assign o_pix.out_green   = r_out.green;
    assign o_pix.out_blue    = r_out.blue;
    assign o_pix.format_bad  = r_out.bad;

    // checks
    `PFC_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_out_v)
    `PFC_ASSERT_NOW(a_bad_zero, o_pix.valid && o_pix.format_bad,
        o_pix.packed_word == '0 && o_pix.out_red == '0 && o_pix.out_green == '0 &&
        o_pix.out_blue == '0)
    `PFC_ASSERT_NEXT(a_skid_fill, !r_skid_v && r_vld[NC] && r_out_v && !o_pix.ready,
        r_skid_v)
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    logic i_clk;
    logic i_rst_n;

    pfc_pix_in_if  pix_in ();
    pfc_pix_out_if pix_out ();
    pfc_cfg_if     cfg ();

    pixel_format_converter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source),
        .i_cfg   (cfg.sink)
    );

    localparam int LATENCY   = 43;
    localparam int N_RANDOM  = 800;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [31:0] word;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        bad;
    } pixel_res_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] word;
        logic        check_now;
        pixel_res_t  res;
    } pixel_row_t;

    // shadow registers
    logic [1:0]  fmt_shadow;
    logic [31:0] mask_shadow [3];

    pixel_res_t expected_pixels [$];
    int         mismatch_cnt;
    int         cycle_cnt;
    bit         stall_long;
    bit         stall_go;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_CAP) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // lowest run of ones in a mask
    function automatic void mask_run(input logic [31:0] m, output int sh, output int wd);
        sh = 0;
        wd = 0;
        if (m != 0) begin
            while (sh < 31 && !m[sh]) sh++;
            while (sh + wd < 32 && m[sh+wd]) wd++;
        end
    endfunction

    function automatic logic [31:0] scale_to_mask(input logic [7:0] v, input logic [31:0] m);
        int          sh;
        int          wd;
        logic [63:0] mx;
        logic [63:0] sc;
        mask_run(m, sh, wd);
        if (wd == 0) return 32'd0;
        mx = (64'd1 << wd) - 1;
        sc = (64'(v) * mx + 64'd127) / 64'd255;
        return 32'((sc << sh) & 64'(m));
    endfunction

    function automatic logic [7:0] scale_from_mask(input logic [31:0] w, input logic [31:0] m);
        int          sh;
        int          wd;
        logic [63:0] mx;
        logic [63:0] v;
        mask_run(m, sh, wd);
        if (wd == 0) return 8'd0;
        mx = (64'd1 << wd) - 1;
        v  = 64'((w & m) >> sh);
        return 8'((v * 64'd255 + (mx >> 1)) / mx);
    endfunction

    function automatic pixel_res_t convert_pixel(input pixel_row_t it);
        pixel_res_t r;
        r = '0;
        if (fmt_shadow == pfc_pkg::FMT_BAD) begin
            r.bad = 1'b1;
        end else if (!it.func) begin
            case (fmt_shadow)
                pfc_pkg::FMT_RGBX: r.word = {8'd0, it.blue, it.green, it.red};
                pfc_pkg::FMT_BGRX: r.word = {8'd0, it.red, it.green, it.blue};
                default:  r.word = scale_to_mask(it.red, mask_shadow[0])
                                 | scale_to_mask(it.green, mask_shadow[1])
                                 | scale_to_mask(it.blue, mask_shadow[2]);
            endcase
        end else begin
            case (fmt_shadow)
                pfc_pkg::FMT_RGBX: begin
                    r.red = it.word[7:0]; r.green = it.word[15:8]; r.blue = it.word[23:16];
                end
                pfc_pkg::FMT_BGRX: begin
                    r.blue = it.word[7:0]; r.green = it.word[15:8]; r.red = it.word[23:16];
                end
                default: begin
                    r.red   = scale_from_mask(it.word, mask_shadow[0]);
                    r.green = scale_from_mask(it.word, mask_shadow[1]);
                    r.blue  = scale_from_mask(it.word, mask_shadow[2]);
                end
            endcase
        end
        return r;
    endfunction

    // register write, block idle; valid stays up for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            pfc_pkg::REG_FORMAT: fmt_shadow <= val[1:0];
            pfc_pkg::REG_RED:    mask_shadow[0] <= val;
            pfc_pkg::REG_GREEN:  mask_shadow[1] <= val;
            default:    mask_shadow[2] <= val;
        endcase
    endtask

    task automatic set_format(input logic [1:0] f, input logic [31:0] rm,
                              input logic [31:0] gm, input logic [31:0] bm);
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        write_reg(pfc_pkg::REG_RED, rm);
        write_reg(pfc_pkg::REG_GREEN, gm);
        write_reg(pfc_pkg::REG_BLUE, bm);
        write_reg(pfc_pkg::REG_FORMAT, f);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one pixel item, random gap first; valid stays up for a following item
    task automatic send_pixel(input pixel_row_t it, input bit gaps);
        pixel_res_t exp_res;
        int         idle;
        idle = gaps ? int'($urandom_range(0, 8)) : 0;
        if (idle != 0) begin
            pix_in.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        exp_res = it.check_now ? it.res : convert_pixel(it);
        pix_in.valid    <= 1'b1;
        pix_in.func     <= it.func;
        pix_in.in_red   <= it.red;
        pix_in.in_green <= it.green;
        pix_in.in_blue  <= it.blue;
        pix_in.raw_word <= it.word;
        do @(posedge i_clk); while (!pix_in.ready);
        expected_pixels.push_back(exp_res);
    endtask

    function automatic pixel_row_t random_pixel();
        pixel_row_t it;
        it = '0;
        it.func  = 1'($urandom_range(0, 1));
        it.red   = 8'($urandom);
        it.green = 8'($urandom);
        it.blue  = 8'($urandom);
        it.word  = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] random_mask();
        int sh;
        int wd;
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: begin
                wd = $urandom_range(1, 12);
                sh = $urandom_range(0, 32 - wd);
                return 32'(((64'd1 << wd) - 1) << sh);
            end
        endcase
    endfunction

    // result checker with random stalls
    initial begin
        pixel_res_t want;
        pixel_res_t got;
        int         idle;
        mismatch_cnt  = 0;
        pix_out.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (stall_long) begin
                pix_out.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                idle = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
                if (idle != 0) begin
                    pix_out.ready <= 1'b0;
                    repeat (idle) @(posedge i_clk);
                end
                pix_out.ready <= 1'b1;
                @(posedge i_clk);
                if (pix_out.valid && pix_out.ready) begin
                    got = {pix_out.packed_word, pix_out.out_red, pix_out.out_green,
                           pix_out.out_blue, pix_out.format_bad};
                    if (expected_pixels.size() == 0) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
                    end else begin
                        want = expected_pixels.pop_front();
                        if (got !== want) begin
                            mismatch_cnt++;
                            if (mismatch_cnt <= 10)
                                $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                         want.word, want.red, want.green, want.blue, want.bad,
                                         got.word, got.red, got.green, got.blue, got.bad);
                        end
                    end
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    initial begin
        stall_long = 1'b0;
        wait (stall_go);
        @(posedge i_clk);
        stall_long = 1'b1;
        repeat (200) @(posedge i_clk);
        stall_long = 1'b0;
    end

    pixel_row_t directed_rows [$];

    // main stimulus
    initial begin
        pixel_row_t it;
        int         wait_cnt;
        i_rst_n         <= 1'b0;
        pix_in.valid    <= 1'b0;
        pix_in.func     <= 1'b0;
        pix_in.in_red   <= '0;
        pix_in.in_green <= '0;
        pix_in.in_blue  <= '0;
        pix_in.raw_word <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= '0;
        cfg.data        <= '0;
        fmt_shadow       = pfc_pkg::FMT_RGBX;
        mask_shadow[0]   = '0;
        mask_shadow[1]   = '0;
        mask_shadow[2]   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset, byte order rgbx: results read off directly
        directed_rows.push_back({1'b0, 8'hFF, 8'h00, 8'hA5, 32'h0, 1'b1,
                                 pixel_res_t'({32'h00A5_00FF, 8'd0, 8'd0, 8'd0, 1'b0})});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'hFF12_3456, 1'b1,
                                 pixel_res_t'({32'h0, 8'h56, 8'h34, 8'h12, 1'b0})});
        directed_rows.push_back({1'b0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                                 pixel_res_t'('0)});
        directed_rows.push_back({1'b0, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b1,
                                 pixel_res_t'({32'h00FF_FFFF, 8'd0, 8'd0, 8'd0, 1'b0})});
        foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b0);

        // bgrx order
        set_format(pfc_pkg::FMT_BGRX, 32'h0, 32'h0, 32'h0);
        directed_rows = {};
        directed_rows.push_back({1'b0, 8'h11, 8'h22, 8'h33, 32'h0, 1'b1,
                                 pixel_res_t'({32'h0011_2233, 8'd0, 8'd0, 8'd0, 1'b0})});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'hAB11_2233, 1'b1,
                                 pixel_res_t'({32'h0, 8'h11, 8'h22, 8'h33, 1'b0})});
        foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b0);

        // invalid format flags every item
        set_format(pfc_pkg::FMT_BAD, 32'h0, 32'h0, 32'h0);
        directed_rows = {};
        directed_rows.push_back({1'b0, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b1,
                                 pixel_res_t'({32'h0, 8'd0, 8'd0, 8'd0, 1'b1})});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                                 pixel_res_t'({32'h0, 8'd0, 8'd0, 8'd0, 1'b1})});
        foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b0);

        // rgb565 style masks, extremes of the channels and mid values
        set_format(pfc_pkg::FMT_MASK, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
        directed_rows = {};
        directed_rows.push_back({1'b0, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b1,
                                 pixel_res_t'({32'h0000_FFFF, 8'd0, 8'd0, 8'd0, 1'b0})});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                                 pixel_res_t'({32'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0})});
        directed_rows.push_back({1'b0, 8'h80, 8'h7F, 8'h01, 32'h0, 1'b0, pixel_res_t'('0)});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'h0000_8410, 1'b0,
                                 pixel_res_t'('0)});
        foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b0);

        // zero mask, full-width mask and a split mask
        set_format(pfc_pkg::FMT_MASK, 32'h0, 32'hFFFF_FFFF, 32'hF0F0_0F0F);
        directed_rows = {};
        directed_rows.push_back({1'b0, 8'hFF, 8'hFF, 8'hFF, 32'h0, 1'b0, pixel_res_t'('0)});
        directed_rows.push_back({1'b0, 8'h5A, 8'h01, 8'hFE, 32'h0, 1'b0, pixel_res_t'('0)});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0,
                                 pixel_res_t'('0)});
        directed_rows.push_back({1'b1, 8'h00, 8'h00, 8'h00, 32'h8000_0001, 1'b0,
                                 pixel_res_t'('0)});
        foreach (directed_rows[i]) send_pixel(directed_rows[i], 1'b0);

        // random phases under varied register settings
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                set_format($urandom_range(0, 9) == 0 ? pfc_pkg::FMT_BAD
                                                     : 2'($urandom_range(0, 2)),
                           random_mask(), random_mask(), random_mask());
            // receiver holds off during a back-to-back phase so the block fills
            if (n == 205) stall_go = 1'b1;
            it = random_pixel();
            send_pixel(it, $urandom_range(0, 3) != 0 && (n % 200) >= 50);
        end
        pix_in.valid <= 1'b0;

        wait_cnt = 0;
        while (expected_pixels.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
